[hdl/sfrm_pkg.sv]
// Shared types, constants and pointer helpers for the slotted frame ring mailbox.
// Used by sfrm_ctrl, sfrm_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package sfrm_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_BYTES = 2048;

    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int PTR_W     = SLOT_W + 1;
    localparam int LEN_W     = 12;
    localparam int FLEN_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int MEM_DEPTH = SLOT_COUNT * SLOT_BYTES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH_START = 2'd0,
        OP_PUSH_BYTE  = 2'd1,
        OP_POP_START  = 2'd2,
        OP_POP_BYTE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_TOO_LONG = 3'd3,
        STAT_SEQ      = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic exec;    // execute the request on the input bus
        logic finish;  // load the buffer read data and present the result
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_read;  // the request on the input bus is a pop byte with a pop open
        logic out_busy;   // result register holds a result that is not taken this cycle
    } t_dp_stat;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(2 * SLOT_COUNT - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
        return (p < PTR_W'(SLOT_COUNT)) ? SLOT_W'(p) : SLOT_W'(p - PTR_W'(SLOT_COUNT));
    endfunction

endpackage

[hdl/sfrm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Holds the frame bytes of all slots; no dependencies.
`timescale 1ns / 1ps

module sfrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sfrm_ctrl.sv]
// Request sequencer for the mailbox: handshake on the input side and the
// wait for the frame buffer read. Uses sfrm_pkg types.
`timescale 1ns / 1ps

module sfrm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  sfrm_pkg::t_dp_stat i_stat,
    output sfrm_pkg::t_ctl_cmd o_cmd
);

    sfrm_pkg::t_state r_state;
    sfrm_pkg::t_state n_state;
    logic             w_ready;
    logic             w_exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfrm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfrm_pkg::S_IDLE: begin
                if (w_exec && i_stat.need_read) begin
                    n_state = sfrm_pkg::S_READ;
                end
            end
            sfrm_pkg::S_READ: begin
                n_state = sfrm_pkg::S_IDLE;
            end
            default: n_state = sfrm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_ready = 1'b0;
        unique case (r_state)
            sfrm_pkg::S_IDLE: w_ready = !i_stat.out_busy;
            sfrm_pkg::S_READ: w_ready = 1'b0;
            default:          w_ready = 1'b0;
        endcase
        w_exec       = i_s_tvalid && w_ready;
        o_s_tready   = w_ready;
        o_cmd.exec   = w_exec;
        o_cmd.finish = (r_state == sfrm_pkg::S_READ);
    end

endmodule

[hdl/sfrm_dp.sv]
// Mailbox datapath: ring pointers, push/pop bookkeeping, slot lengths,
// frame buffer and the result register. Uses sfrm_pkg and sfrm_ram.
`timescale 1ns / 1ps

module sfrm_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sfrm_pkg::t_ctl_cmd                i_cmd,
    output sfrm_pkg::t_dp_stat                o_stat,
    input  logic [sfrm_pkg::IN_DATA_W-1:0]    i_in_data,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [sfrm_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tlast
);

    localparam int PW = sfrm_pkg::PTR_W;
    localparam int LW = sfrm_pkg::LEN_W;
    localparam int AW = sfrm_pkg::ADDR_W;

    // request fields
    sfrm_pkg::t_op                w_op;
    logic [sfrm_pkg::FLEN_W-1:0]  w_flen;
    logic [sfrm_pkg::BYTE_W-1:0]  w_byte;

    // ring state
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic          r_push_active, n_push_active;
    logic [LW-1:0] r_push_offset, n_push_offset;
    logic [LW-1:0] r_push_target, n_push_target;
    logic          r_pop_active, n_pop_active;
    logic [LW-1:0] r_pop_offset, n_pop_offset;
    logic [LW-1:0] r_pop_target, n_pop_target;

    logic [LW-1:0] r_slot_len [sfrm_pkg::SLOT_COUNT];

    // result register
    logic                        r_out_valid, n_out_valid;
    sfrm_pkg::t_status           r_status, n_status;
    logic                        r_committed, n_committed;
    logic                        r_freed, n_freed;
    logic [LW-1:0]               r_out_len, n_out_len;
    logic [sfrm_pkg::BYTE_W-1:0] r_data_out, n_data_out;
    logic                        r_last, n_last;

    logic [PW-1:0]                 w_occ;
    logic                          w_full;
    logic                          w_empty;
    logic [sfrm_pkg::SLOT_W-1:0]   w_head_slot;
    logic [sfrm_pkg::SLOT_W-1:0]   w_tail_slot;
    logic [LW-1:0]                 w_tail_len;
    logic [LW-1:0]                 w_push_inc;
    logic [LW-1:0]                 w_pop_inc;
    logic                          w_len_we;
    logic [LW-1:0]                 w_len_wdata;
    logic                          w_mem_we;
    logic [AW-1:0]                 w_waddr;
    logic [AW-1:0]                 w_raddr;
    logic [sfrm_pkg::BYTE_W-1:0]   w_rdata;

    assign w_op   = sfrm_pkg::t_op'(i_in_data[1:0]);
    assign w_flen = i_in_data[17:2];
    assign w_byte = i_in_data[25:18];

    assign w_head_slot = sfrm_pkg::slot_of(r_head);
    assign w_tail_slot = sfrm_pkg::slot_of(r_tail);
    assign w_occ   = (r_head >= r_tail) ? r_head - r_tail
                                        : r_head + PW'(2 * sfrm_pkg::SLOT_COUNT) - r_tail;
    assign w_full  = (w_occ >= PW'(sfrm_pkg::SLOT_COUNT));
    assign w_empty = (r_head == r_tail);

    // clamp the stored length to the slot size
    assign w_tail_len = (r_slot_len[w_tail_slot] > LW'(sfrm_pkg::SLOT_BYTES))
                      ? LW'(sfrm_pkg::SLOT_BYTES) : r_slot_len[w_tail_slot];

    assign w_push_inc = r_push_offset + LW'(1);
    assign w_pop_inc  = r_pop_offset + LW'(1);

    assign w_waddr = AW'(w_head_slot) * AW'(sfrm_pkg::SLOT_BYTES) + AW'(r_push_offset);
    assign w_raddr = AW'(w_tail_slot) * AW'(sfrm_pkg::SLOT_BYTES) + AW'(r_pop_offset);

    assign o_stat.need_read = (w_op == sfrm_pkg::OP_POP_BYTE) && r_pop_active;
    assign o_stat.out_busy  = r_out_valid && !i_m_tready;

    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_push_active = r_push_active;
        n_push_offset = r_push_offset;
        n_push_target = r_push_target;
        n_pop_active  = r_pop_active;
        n_pop_offset  = r_pop_offset;
        n_pop_target  = r_pop_target;
        n_status      = r_status;
        n_committed   = r_committed;
        n_freed       = r_freed;
        n_out_len     = r_out_len;
        n_data_out    = r_data_out;
        n_last        = r_last;
        n_out_valid   = r_out_valid && !i_m_tready;
        w_len_we      = 1'b0;
        w_len_wdata   = '0;
        w_mem_we      = 1'b0;

        if (i_cmd.finish) begin
            n_data_out  = w_rdata;
            n_out_valid = 1'b1;
        end else if (i_cmd.exec) begin
            n_status    = sfrm_pkg::STAT_OK;
            n_committed = 1'b0;
            n_freed     = 1'b0;
            n_out_len   = '0;
            n_data_out  = '0;
            n_last      = 1'b0;
            // pop byte waits in the read state for the registered buffer read
            n_out_valid = !o_stat.need_read;
            unique case (w_op)
                sfrm_pkg::OP_PUSH_START: begin
                    if (r_push_active) begin
                        n_status = sfrm_pkg::STAT_SEQ;
                    end else if (32'(w_flen) > 32'(sfrm_pkg::SLOT_BYTES)) begin
                        n_status = sfrm_pkg::STAT_TOO_LONG;
                    end else if (w_full) begin
                        n_status = sfrm_pkg::STAT_FULL;
                    end else if (w_flen == '0) begin
                        // empty frame commits at once
                        w_len_we    = 1'b1;
                        n_head      = sfrm_pkg::ptr_next(r_head);
                        n_committed = 1'b1;
                    end else begin
                        n_push_active = 1'b1;
                        n_push_offset = '0;
                        n_push_target = LW'(w_flen);
                    end
                end
                sfrm_pkg::OP_PUSH_BYTE: begin
                    if (!r_push_active) begin
                        n_status = sfrm_pkg::STAT_SEQ;
                    end else begin
                        w_mem_we      = 1'b1;
                        n_push_offset = w_push_inc;
                        if (w_push_inc >= r_push_target) begin
                            w_len_we      = 1'b1;
                            w_len_wdata   = r_push_target;
                            n_head        = sfrm_pkg::ptr_next(r_head);
                            n_push_active = 1'b0;
                            n_push_offset = '0;
                            n_committed   = 1'b1;
                        end
                    end
                end
                sfrm_pkg::OP_POP_START: begin
                    if (r_pop_active) begin
                        n_status = sfrm_pkg::STAT_SEQ;
                    end else if (w_empty) begin
                        n_status = sfrm_pkg::STAT_EMPTY;
                    end else begin
                        n_out_len = w_tail_len;
                        if (w_tail_len == '0) begin
                            n_tail  = sfrm_pkg::ptr_next(r_tail);
                            n_freed = 1'b1;
                        end else begin
                            n_pop_active = 1'b1;
                            n_pop_offset = '0;
                            n_pop_target = w_tail_len;
                        end
                    end
                end
                sfrm_pkg::OP_POP_BYTE: begin
                    if (!r_pop_active) begin
                        n_status = sfrm_pkg::STAT_SEQ;
                    end else begin
                        n_pop_offset = w_pop_inc;
                        if (w_pop_inc >= r_pop_target) begin
                            n_last       = 1'b1;
                            n_tail       = sfrm_pkg::ptr_next(r_tail);
                            n_pop_active = 1'b0;
                            n_pop_offset = '0;
                            n_freed      = 1'b1;
                        end
                    end
                end
                default: n_status = sfrm_pkg::STAT_SEQ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_push_active <= 1'b0;
            r_push_offset <= '0;
            r_push_target <= '0;
            r_pop_active  <= 1'b0;
            r_pop_offset  <= '0;
            r_pop_target  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_push_active <= n_push_active;
            r_push_offset <= n_push_offset;
            r_push_target <= n_push_target;
            r_pop_active  <= n_pop_active;
            r_pop_offset  <= n_pop_offset;
            r_pop_target  <= n_pop_target;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_committed <= n_committed;
        r_freed     <= n_freed;
        r_out_len   <= n_out_len;
        r_data_out  <= n_data_out;
        r_last      <= n_last;
        if (w_len_we) begin
            r_slot_len[w_head_slot] <= w_len_wdata;
        end
    end

    sfrm_ram #(
        .WIDTH (sfrm_pkg::BYTE_W),
        .DEPTH (sfrm_pkg::MEM_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (w_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {
        (sfrm_pkg::OUT_DATA_W - 25)'(0),
        r_data_out,
        r_out_len,
        r_freed,
        r_committed,
        r_status
    };

endmodule

[hdl/slotted_frame_ring_mailbox.sv]
// Top level of the slotted frame ring mailbox: a ring of frame slots passed
// from one producer to one consumer. Instantiates sfrm_ctrl and sfrm_dp.
//
//   channel   | direction | contents
//   s_axis    | in        | request: tdata = op, frame_len, data_byte
//   m_axis    | out       | result: tdata = status, committed, freed, out_len, data_out;
//             |           |         tlast = last
//
// Push start, push byte, pop start and an out-of-sequence pop byte load the result on acceptance;
// a pop byte with a pop open waits in the read state for the frame buffer RAM's registered read.
// The result register lets the next request in while the previous result is taken.
// Reset clears pointers and push/pop state at once; buffer and slot lengths are
// not cleared, so no clearing pass follows reset.
// A stalled output holds its result and blocks new requests until it is taken.
`timescale 1ns / 1ps

module slotted_frame_ring_mailbox (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] op, [17:2] frame_len, [25:18] data_byte, [31:26] zero
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [3] committed, [4] freed, [16:5] out_len, [24:17] data_out,
    // [31:25] zero
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    sfrm_pkg::t_ctl_cmd w_cmd;
    sfrm_pkg::t_dp_stat w_stat;

    sfrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sfrm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_in_data  (s_axis_tdata),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

[test/slotted_frame_ring_mailbox_test.sv]
// Self-checking bench for the slotted frame ring mailbox: a directed request table,
// a ring fill and random push/pop traffic against a local model.
// Depends on sfrm_pkg and slotted_frame_ring_mailbox.
`timescale 1ns / 1ps

module slotted_frame_ring_mailbox_test;

    localparam int RING_SPAN    = 2 * sfrm_pkg::SLOT_COUNT;
    localparam int RANDOM_ITEMS = 980;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        sfrm_pkg::t_status           status;
        logic                        committed;
        logic                        freed;
        logic [sfrm_pkg::LEN_W-1:0]  out_len;
        logic [sfrm_pkg::BYTE_W-1:0] data_out;
        logic                        last;
    } mbox_result_t;

    typedef struct packed {
        sfrm_pkg::t_op               op;
        logic [sfrm_pkg::FLEN_W-1:0] frame_len;
        logic [sfrm_pkg::BYTE_W-1:0] data_byte;
        logic                        fixed;
        mbox_result_t                want;
    } directed_row_t;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [sfrm_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [sfrm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;

    // mailbox model state
    logic [sfrm_pkg::BYTE_W-1:0] frame_store [sfrm_pkg::MEM_DEPTH];
    logic [sfrm_pkg::LEN_W-1:0]  frame_len_store [sfrm_pkg::SLOT_COUNT];
    int                head_ptr = 0;
    int                tail_ptr = 0;
    bit                push_open = 1'b0;
    int                push_pos = 0;
    int                push_want = 0;
    bit                pop_open = 1'b0;
    int                pop_pos = 0;
    int                pop_want = 0;

    mbox_result_t      pending_results [$];
    mbox_result_t      got_res;
    mbox_result_t      want_res;

    int n_requests = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int n_committed = 0;
    int n_freed = 0;
    int status_hits [8];
    int burst_left = 0;
    int idle_cycles = 0;
    bit rx_hold_go = 1'b0;
    bit rx_hold_done = 1'b0;
    int rx_hold_left = 0;
    bit [31:0] rx_tick = '0;

    // [1:0] op, [17:2] frame_len, [25:18] data_byte; rows with fixed=1 carry their result
    directed_row_t directed_rows [21] = '{
        '{sfrm_pkg::OP_POP_START,  16'd0,     8'h00, 1'b1,
          '{sfrm_pkg::STAT_EMPTY,    1'b0, 1'b0, 12'd0, 8'd0, 1'b0}},
        '{sfrm_pkg::OP_POP_BYTE,   16'hFFFF,  8'hFF, 1'b1,
          '{sfrm_pkg::STAT_SEQ,      1'b0, 1'b0, 12'd0, 8'd0, 1'b0}},
        '{sfrm_pkg::OP_PUSH_BYTE,  16'd0,     8'hFF, 1'b1,
          '{sfrm_pkg::STAT_SEQ,      1'b0, 1'b0, 12'd0, 8'd0, 1'b0}},
        '{sfrm_pkg::OP_PUSH_START, 16'd2049,  8'h00, 1'b1,
          '{sfrm_pkg::STAT_TOO_LONG, 1'b0, 1'b0, 12'd0, 8'd0, 1'b0}},
        '{sfrm_pkg::OP_PUSH_START, 16'hFFFF,  8'hFF, 1'b1,
          '{sfrm_pkg::STAT_TOO_LONG, 1'b0, 1'b0, 12'd0, 8'd0, 1'b0}},
        '{sfrm_pkg::OP_PUSH_START, 16'd0,     8'h00, 1'b1,
          '{sfrm_pkg::STAT_OK,       1'b1, 1'b0, 12'd0, 8'd0, 1'b0}},
        '{sfrm_pkg::OP_POP_START,  16'd0,     8'h00, 1'b1,
          '{sfrm_pkg::STAT_OK,       1'b0, 1'b1, 12'd0, 8'd0, 1'b0}},
        '{sfrm_pkg::OP_PUSH_START, 16'd3,     8'h00, 1'b1,
          '{sfrm_pkg::STAT_OK,       1'b0, 1'b0, 12'd0, 8'd0, 1'b0}},
        '{sfrm_pkg::OP_PUSH_START, 16'd2048,  8'h00, 1'b1,
          '{sfrm_pkg::STAT_SEQ,      1'b0, 1'b0, 12'd0, 8'd0, 1'b0}},
        '{sfrm_pkg::OP_PUSH_BYTE,  16'd0,     8'h00, 1'b0, '0},
        '{sfrm_pkg::OP_PUSH_BYTE,  16'hFFFF,  8'hFF, 1'b0, '0},
        '{sfrm_pkg::OP_PUSH_BYTE,  16'd0,     8'hA5, 1'b0, '0},
        '{sfrm_pkg::OP_POP_START,  16'd0,     8'h00, 1'b1,
          '{sfrm_pkg::STAT_OK,       1'b0, 1'b0, 12'd3, 8'd0, 1'b0}},
        '{sfrm_pkg::OP_POP_START,  16'd0,     8'h00, 1'b1,
          '{sfrm_pkg::STAT_SEQ,      1'b0, 1'b0, 12'd0, 8'd0, 1'b0}},
        '{sfrm_pkg::OP_POP_BYTE,   16'd0,     8'h00, 1'b0, '0},
        '{sfrm_pkg::OP_POP_BYTE,   16'd0,     8'h00, 1'b0, '0},
        '{sfrm_pkg::OP_POP_BYTE,   16'd0,     8'h00, 1'b0, '0},
        '{sfrm_pkg::OP_PUSH_START, 16'd1,     8'h00, 1'b0, '0},
        '{sfrm_pkg::OP_PUSH_BYTE,  16'd0,     8'h5A, 1'b0, '0},
        '{sfrm_pkg::OP_POP_START,  16'd0,     8'h00, 1'b0, '0},
        '{sfrm_pkg::OP_POP_BYTE,   16'd0,     8'h00, 1'b0, '0}
    };

    slotted_frame_ring_mailbox i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int ring_fill();
        return (head_ptr + RING_SPAN - tail_ptr) % RING_SPAN;
    endfunction

    function automatic int ring_next(input int p);
        return (p == RING_SPAN - 1) ? 0 : p + 1;
    endfunction

    // Apply one request to the mailbox model and return the result it produces.
    function automatic mbox_result_t mailbox_step(input sfrm_pkg::t_op op,
                                                  input logic [sfrm_pkg::FLEN_W-1:0] flen,
                                                  input logic [sfrm_pkg::BYTE_W-1:0] dbyte);
        mbox_result_t r;
        int slot;
        int len;
        r = '0;
        r.status = sfrm_pkg::STAT_OK;
        case (op)
            sfrm_pkg::OP_PUSH_START: begin
                if (push_open) begin
                    r.status = sfrm_pkg::STAT_SEQ;
                end else if (flen > sfrm_pkg::SLOT_BYTES) begin
                    r.status = sfrm_pkg::STAT_TOO_LONG;
                end else if (ring_fill() >= sfrm_pkg::SLOT_COUNT) begin
                    r.status = sfrm_pkg::STAT_FULL;
                end else if (flen == 0) begin
                    frame_len_store[head_ptr % sfrm_pkg::SLOT_COUNT] = '0;
                    head_ptr = ring_next(head_ptr);
                    r.committed = 1'b1;
                end else begin
                    push_open = 1'b1;
                    push_pos = 0;
                    push_want = flen;
                end
            end
            sfrm_pkg::OP_PUSH_BYTE: begin
                if (!push_open) begin
                    r.status = sfrm_pkg::STAT_SEQ;
                end else begin
                    slot = head_ptr % sfrm_pkg::SLOT_COUNT;
                    frame_store[slot * sfrm_pkg::SLOT_BYTES + push_pos] = dbyte;
                    push_pos++;
                    if (push_pos >= push_want) begin
                        frame_len_store[slot] = sfrm_pkg::LEN_W'(push_want);
                        head_ptr = ring_next(head_ptr);
                        push_open = 1'b0;
                        push_pos = 0;
                        r.committed = 1'b1;
                    end
                end
            end
            sfrm_pkg::OP_POP_START: begin
                if (pop_open) begin
                    r.status = sfrm_pkg::STAT_SEQ;
                end else if (ring_fill() == 0) begin
                    r.status = sfrm_pkg::STAT_EMPTY;
                end else begin
                    len = frame_len_store[tail_ptr % sfrm_pkg::SLOT_COUNT];
                    if (len > sfrm_pkg::SLOT_BYTES) len = sfrm_pkg::SLOT_BYTES;
                    r.out_len = sfrm_pkg::LEN_W'(len);
                    if (len == 0) begin
                        tail_ptr = ring_next(tail_ptr);
                        r.freed = 1'b1;
                    end else begin
                        pop_open = 1'b1;
                        pop_pos = 0;
                        pop_want = len;
                    end
                end
            end
            default: begin
                if (!pop_open) begin
                    r.status = sfrm_pkg::STAT_SEQ;
                end else begin
                    slot = tail_ptr % sfrm_pkg::SLOT_COUNT;
                    r.data_out = frame_store[slot * sfrm_pkg::SLOT_BYTES + pop_pos];
                    pop_pos++;
                    if (pop_pos >= pop_want) begin
                        r.last = 1'b1;
                        tail_ptr = ring_next(tail_ptr);
                        pop_open = 1'b0;
                        pop_pos = 0;
                        r.freed = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Mostly short frames, some empty ones, now and then a long one.
    function automatic logic [sfrm_pkg::FLEN_W-1:0] pick_frame_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 80) return sfrm_pkg::FLEN_W'($urandom_range(1, 8));
        if (r < 98) return sfrm_pkg::FLEN_W'($urandom_range(9, 64));
        return sfrm_pkg::FLEN_W'($urandom_range(65, 700));
    endfunction

    function automatic string show_result(input mbox_result_t r);
        return $sformatf("status=%0d committed=%0b freed=%0b out_len=%0d data=%02h last=%0b",
                         r.status, r.committed, r.freed, r.out_len, r.data_out, r.last);
    endfunction

    // Offer one request in bursts with random gaps; on acceptance, record its result.
    task automatic send_request(input sfrm_pkg::t_op op,
                                input logic [sfrm_pkg::FLEN_W-1:0] flen,
                                input logic [sfrm_pkg::BYTE_W-1:0] dbyte,
                                input bit use_fixed = 1'b0, input mbox_result_t fixed_res = '0);
        mbox_result_t predicted;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, dbyte, flen, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = mailbox_step(op, flen, dbyte);
        pending_results.push_back(use_fixed ? fixed_res : predicted);
        n_requests++;
    endtask

    task automatic producer_step();
        if (push_open)
            send_request(sfrm_pkg::OP_PUSH_BYTE, sfrm_pkg::FLEN_W'($urandom),
                         sfrm_pkg::BYTE_W'($urandom));
        else
            send_request(sfrm_pkg::OP_PUSH_START, pick_frame_len(),
                         sfrm_pkg::BYTE_W'($urandom));
    endtask

    task automatic consumer_step();
        if (pop_open)
            send_request(sfrm_pkg::OP_POP_BYTE, sfrm_pkg::FLEN_W'($urandom),
                         sfrm_pkg::BYTE_W'($urandom));
        else
            send_request(sfrm_pkg::OP_POP_START, sfrm_pkg::FLEN_W'($urandom),
                         sfrm_pkg::BYTE_W'($urandom));
    endtask

    task automatic log_mismatch(input string what, input mbox_result_t want,
                                input mbox_result_t got);
        if (n_mismatch < MAX_REPORTS)
            $display("%0t ns: %s\n  expected %s\n  actual   %s", $time, what,
                     show_result(want), show_result(got));
        n_mismatch++;
    endtask

    // Receiver: rotate through stall patterns; hold off once for a long stretch.
    always @(posedge i_clk) begin
        rx_tick++;
        if (rx_hold_go && !rx_hold_done) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_done = 1'b1;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_tick[7:6])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= $urandom_range(0, 1);
                2'd2: m_axis_tready <= (rx_tick[1:0] == 2'd0);
                default: m_axis_tready <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res.status    = sfrm_pkg::t_status'(m_axis_tdata[2:0]);
            got_res.committed = m_axis_tdata[3];
            got_res.freed     = m_axis_tdata[4];
            got_res.out_len   = m_axis_tdata[16:5];
            got_res.data_out  = m_axis_tdata[24:17];
            got_res.last      = m_axis_tlast;
            n_results++;
            status_hits[int'(m_axis_tdata[2:0])]++;
            if (got_res.committed === 1'b1) n_committed++;
            if (got_res.freed === 1'b1) n_freed++;
            if (pending_results.size() == 0) begin
                log_mismatch("result with no request pending", '0, got_res);
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.status !== want_res.status || got_res.committed !== want_res.committed
                        || got_res.freed !== want_res.freed
                        || got_res.out_len !== want_res.out_len
                        || got_res.data_out !== want_res.data_out
                        || got_res.last !== want_res.last)
                    log_mismatch("result mismatch", want_res, got_res);
            end
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: %0d cycles without a transfer, %0d results pending",
                     idle_cycles, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int start_count;
        int bias;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_request(directed_rows[k].op, directed_rows[k].frame_len,
                         directed_rows[k].data_byte, directed_rows[k].fixed,
                         directed_rows[k].want);

        // fill the ring, hit full and the length check ahead of it, then drain
        while (ring_fill() < sfrm_pkg::SLOT_COUNT) begin
            send_request(sfrm_pkg::OP_PUSH_START, sfrm_pkg::FLEN_W'($urandom_range(0, 4)),
                         sfrm_pkg::BYTE_W'($urandom));
            while (push_open) producer_step();
        end
        send_request(sfrm_pkg::OP_PUSH_START,
                     sfrm_pkg::FLEN_W'($urandom_range(1, sfrm_pkg::SLOT_BYTES)),
                     sfrm_pkg::BYTE_W'($urandom));
        send_request(sfrm_pkg::OP_PUSH_START, sfrm_pkg::FLEN_W'(sfrm_pkg::SLOT_BYTES + 1),
                     sfrm_pkg::BYTE_W'($urandom));
        while (ring_fill() != 0 || pop_open) consumer_step();

        // random traffic; the receiver holds off at the start so the block backs up
        rx_hold_go = 1'b1;
        start_count = n_requests;
        while (n_requests - start_count < RANDOM_ITEMS) begin
            bias = (((n_requests - start_count) / 150) % 2 == 0) ? 70 : 30;
            if ($urandom_range(0, 99) < 8)
                send_request(sfrm_pkg::t_op'($urandom_range(0, 3)),
                             sfrm_pkg::FLEN_W'($urandom), sfrm_pkg::BYTE_W'($urandom));
            else if ($urandom_range(0, 99) < bias)
                producer_step();
            else
                consumer_step();
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests, checked %0d results: %0d frames committed, %0d freed.",
                 n_requests, n_results, n_committed, n_freed);
        $display("Status mix: ok %0d, empty %0d, full %0d, too long %0d, out of sequence %0d.",
                 status_hits[sfrm_pkg::STAT_OK], status_hits[sfrm_pkg::STAT_EMPTY],
                 status_hits[sfrm_pkg::STAT_FULL], status_hits[sfrm_pkg::STAT_TOO_LONG],
                 status_hits[sfrm_pkg::STAT_SEQ]);
        if (n_mismatch == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
